FILE: rtl/pclb_pkg.sv
// package for the particle cell list binner: word types, codes, constants
// and the command/status structs between controller and datapath
// no dependencies
package pclb_pkg;

  localparam int unsigned DIV_W  = 33;
  localparam int unsigned AXIS_W = 13;
  localparam int unsigned PLANE_W = 2 * AXIS_W;
  localparam int unsigned TOT_W  = 3 * AXIS_W;
  localparam int unsigned CFG_AW = 4;

  localparam logic [AXIS_W-1:0]  AXIS_SAT  = 13'd8191;
  localparam logic [AXIS_W-1:0]  RST_AXIS  = 13'd16;
  localparam logic [PLANE_W-1:0] RST_PLANE = 26'd256;
  localparam logic [AXIS_W-1:0]  RST_TOTAL = 13'd4096;
  localparam logic [31:0]        RST_CELL_LEN = 32'd65536;
  localparam logic [31:0]        RST_BOX_LEN  = 32'd1048576;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_CELL_LEN = 2'd0,
    REG_BOX_X    = 2'd1,
    REG_BOX_Y    = 2'd2,
    REG_BOX_Z    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_CFG = 2'd0,
    DIV_POS = 2'd1,
    DIV_IDX = 2'd2,
    DIV_REM = 2'd3
  } div_src_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [11:0] cell_index;
    logic [3:0]  slot;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] cell_id;
    logic [11:0] cell_x;
    logic [11:0] cell_y;
    logic [11:0] cell_z;
    logic [4:0]  cell_count;
    logic [4:0]  max_count;
    logic [15:0] particle_number;
    logic [12:0] total_cells;
  } out_word_t;

  typedef struct packed {
    logic     accept;
    logic     clr_state;
    logic     div_start;
    div_src_e div_src;
    logic     add_chk;
    logic     add_id;
    logic     add_upd;
    logic     cap_cx;
    logic     rd_ent;
    logic     rd_fin;
    logic     sweep;
    logic     cfg_n;
    logic     cfg_p;
    logic     cfg_t;
    logic     reply;
    status_e  status;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic too_large;
    logic exhausted;
    logic idx_out;
    logic in_range;
    logic full;
    logic empty;
    logic sweep_last;
  } stat_t;

  function automatic logic [AXIS_W-1:0] axis_sat(input logic [DIV_W-1:0] q);
    return (q > DIV_W'(AXIS_SAT)) ? AXIS_SAT : q[AXIS_W-1:0];
  endfunction

endpackage

FILE: rtl/pclb_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing
module pclb_div #(
  parameter int unsigned W = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o,
  output logic         done_o
);

  localparam int unsigned CB = $clog2(W + 1);

  logic [W-1:0]  quo_q, rem_q, div_q;
  logic [CB-1:0] cnt_q;
  logic          done_q;
  logic [W:0]    trial, diff;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CB'(W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CB'(1);
        done_q <= (cnt_q == CB'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

FILE: rtl/pclb_dp.sv
// datapath: grid geometry, three divider lanes, count and entry memories
// depends on pclb_pkg and pclb_div
module pclb_dp #(
  parameter int unsigned MAX_CELLS     = 4096,
  parameter int unsigned CELL_CAPACITY = 16,
  parameter int unsigned MAX_PARTICLES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pclb_pkg::cmd_t      cmd_i,
  output pclb_pkg::stat_t     stat_o,
  input  pclb_pkg::in_word_t  in_i,
  input  logic [31:0]         cell_len_i,
  input  logic [31:0]         box_x_i,
  input  logic [31:0]         box_y_i,
  input  logic [31:0]         box_z_i,
  output pclb_pkg::out_word_t res_o
);

  localparam int unsigned CW     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CNTW   = $clog2(CELL_CAPACITY + 1);
  localparam int unsigned EDEPTH = MAX_CELLS * CELL_CAPACITY;
  localparam int unsigned EW     = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int unsigned NPW    = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned CMPW   = (CNTW > 4) ? CNTW : 4;
  localparam int unsigned DW     = pclb_pkg::DIV_W;
  localparam int unsigned AW     = pclb_pkg::AXIS_W;
  localparam int unsigned PW     = pclb_pkg::PLANE_W;
  localparam int unsigned TW     = pclb_pkg::TOT_W;

  // geometry
  logic [AW-1:0] nx_q, ny_q, nz_q, total_q;
  logic [PW-1:0] plane_q;
  logic          too_large_q;
  logic [TW-1:0] tot_raw;

  // running state
  logic [NPW-1:0]  next_q;
  logic [CNTW-1:0] largest_q;
  logic [CW-1:0]   sweep_q;

  // per item work registers
  logic [11:0]     id_q, cx_q, cy_q, cz_q;
  logic [CNTW-1:0] cnt_q;
  logic [15:0]     pnum_q;
  logic [3:0]      slot_q;
  logic            in_range_q;
  logic [AW-1:0]   px_q, py_q, pz_q;
  logic [PW-1:0]   tzy_q;
  logic [TW-1:0]   tx_q;

  // memories
  logic [CNTW-1:0] cnt_mem [MAX_CELLS];
  logic [15:0]     ent_mem [EDEPTH];
  logic [CNTW-1:0] cnt_rd_q;
  logic [15:0]     ent_rd_q;
  logic [EW-1:0]   ent_raddr_q;

  pclb_pkg::out_word_t res_q;

  // dividers
  logic [DW-1:0] div_a [3];
  logic [DW-1:0] div_b [3];
  logic [DW-1:0] quo   [3];
  logic [DW-1:0] rem   [3];
  logic [2:0]    div_done;
  logic [DW-1:0] cell_ext;

  assign cell_ext = {1'b0, cell_len_i};

  always_comb begin
    div_a[0] = {1'b0, in_i.pos_x};
    div_a[1] = {1'b0, in_i.pos_y};
    div_a[2] = {1'b0, in_i.pos_z};
    div_b[0] = cell_ext;
    div_b[1] = cell_ext;
    div_b[2] = cell_ext;
    unique case (cmd_i.div_src)
      pclb_pkg::DIV_CFG: begin
        // ceil(box / cell) as floor((box + cell - 1) / cell)
        div_a[0] = {1'b0, box_x_i} + cell_ext - DW'(1);
        div_a[1] = {1'b0, box_y_i} + cell_ext - DW'(1);
        div_a[2] = {1'b0, box_z_i} + cell_ext - DW'(1);
      end
      pclb_pkg::DIV_POS: begin
      end
      pclb_pkg::DIV_IDX: begin
        div_a[0] = DW'(in_i.cell_index);
        div_b[0] = DW'(plane_q);
      end
      pclb_pkg::DIV_REM: begin
        div_a[0] = rem[0];
        div_b[0] = DW'(nz_q);
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pclb_div #(.W(DW)) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (cmd_i.div_start),
      .dividend_i(div_a[g]),
      .divisor_i (div_b[g]),
      .quo_o     (quo[g]),
      .rem_o     (rem[g]),
      .done_o    (div_done[g])
    );
  end

  // status toward the controller
  logic [CW-1:0]   cidx;
  logic            full;
  logic [CNTW-1:0] cnt_inc;
  logic [CMPW-1:0] ofs_full;
  logic [EW-1:0]   ent_base;

  assign cidx     = CW'(id_q);
  assign full     = cnt_rd_q >= CNTW'(CELL_CAPACITY);
  assign cnt_inc  = cnt_rd_q + CNTW'(1);
  assign ofs_full = CMPW'(cnt_rd_q) - CMPW'(1) - CMPW'(slot_q);
  assign ent_base = EW'(cidx) * EW'(CELL_CAPACITY);
  assign tot_raw  = TW'(nx_q) * TW'(plane_q);

  always_comb begin
    stat_o.div_done   = &div_done;
    stat_o.too_large  = too_large_q;
    stat_o.exhausted  = next_q >= NPW'(MAX_PARTICLES);
    stat_o.idx_out    = {1'b0, in_i.cell_index} >= total_q;
    stat_o.in_range   = in_range_q;
    stat_o.full       = full;
    stat_o.empty      = CMPW'(slot_q) >= CMPW'(cnt_rd_q);
    stat_o.sweep_last = sweep_q == CW'(MAX_CELLS - 1);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q        <= pclb_pkg::RST_AXIS;
      ny_q        <= pclb_pkg::RST_AXIS;
      nz_q        <= pclb_pkg::RST_AXIS;
      plane_q     <= pclb_pkg::RST_PLANE;
      total_q     <= pclb_pkg::RST_TOTAL;
      too_large_q <= (32'(pclb_pkg::RST_TOTAL) > 32'(MAX_CELLS));
      next_q      <= '0;
      largest_q   <= '0;
      sweep_q     <= '0;
    end else begin
      if (cmd_i.cfg_n) begin
        nx_q <= pclb_pkg::axis_sat(quo[0]);
        ny_q <= pclb_pkg::axis_sat(quo[1]);
        nz_q <= pclb_pkg::axis_sat(quo[2]);
      end
      if (cmd_i.cfg_p) begin
        plane_q <= PW'(ny_q) * PW'(nz_q);
      end
      if (cmd_i.cfg_t) begin
        total_q     <= (tot_raw > TW'(pclb_pkg::AXIS_SAT)) ? pclb_pkg::AXIS_SAT
                                                          : tot_raw[AW-1:0];
        too_large_q <= tot_raw > TW'(MAX_CELLS);
      end
      if (cmd_i.clr_state) begin
        next_q    <= '0;
        largest_q <= '0;
      end else if (cmd_i.add_chk) begin
        next_q <= next_q + NPW'(1);
      end else if (cmd_i.add_upd && !full && cnt_inc > largest_q) begin
        largest_q <= cnt_inc;
      end
      if (cmd_i.sweep) begin
        sweep_q <= stat_o.sweep_last ? '0 : sweep_q + CW'(1);
      end
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      id_q   <= (in_i.operation == pclb_pkg::OP_READ && !too_large_q) ?
                in_i.cell_index : '0;
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
      cnt_q  <= '0;
      pnum_q <= '0;
      slot_q <= in_i.slot;
    end
    if (cmd_i.add_chk) begin
      in_range_q <= (quo[0] < DW'(nx_q)) && (quo[1] < DW'(ny_q)) && (quo[2] < DW'(nz_q));
      px_q       <= quo[0][AW-1:0];
      py_q       <= quo[1][AW-1:0];
      pz_q       <= quo[2][AW-1:0];
      tzy_q      <= PW'(nz_q) * PW'(quo[1][AW-1:0]);
      tx_q       <= TW'(plane_q) * TW'(quo[0][AW-1:0]);
      pnum_q     <= 16'(next_q);
    end
    if (cmd_i.add_id) begin
      id_q <= 12'(TW'(pz_q) + TW'(tzy_q) + tx_q);
      cx_q <= 12'(px_q);
      cy_q <= 12'(py_q);
      cz_q <= 12'(pz_q);
    end
    if (cmd_i.add_upd) begin
      cnt_q <= full ? cnt_rd_q : cnt_inc;
    end
    if (cmd_i.cap_cx) begin
      cx_q <= 12'(quo[0]);
    end
    if (cmd_i.rd_ent) begin
      cy_q        <= 12'(quo[0]);
      cz_q        <= 12'(rem[0]);
      cnt_q       <= cnt_rd_q;
      ent_raddr_q <= ent_base + EW'(ofs_full);
    end
    if (cmd_i.rd_fin) begin
      pnum_q <= ent_rd_q;
    end
    if (cmd_i.reply) begin
      res_q.status          <= cmd_i.status;
      res_q.cell_id         <= id_q;
      res_q.cell_x          <= cx_q;
      res_q.cell_y          <= cy_q;
      res_q.cell_z          <= cz_q;
      res_q.cell_count      <= 5'(cnt_q);
      res_q.max_count       <= 5'(largest_q);
      res_q.particle_number <= pnum_q;
      res_q.total_cells     <= total_q;
    end
  end

  // count memory: one write port shared by the clearing sweep and adds
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      cnt_mem[sweep_q] <= '0;
    end else if (cmd_i.add_upd && !full) begin
      cnt_mem[cidx] <= cnt_inc;
    end
    cnt_rd_q <= cnt_mem[cidx];
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_upd && !full) begin
      ent_mem[ent_base + EW'(cnt_rd_q)] <= pnum_q;
    end
    ent_rd_q <= ent_mem[ent_raddr_q];
  end

  assign res_o = res_q;

endmodule

FILE: rtl/pclb_ctrl.sv
// controller state machine: sequences config recompute, add, read and clear
// depends on pclb_pkg
module pclb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            cfg_wr_i,
  input  pclb_pkg::op_e   op_i,
  input  pclb_pkg::stat_t stat_i,
  output pclb_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CFG_S, S_CFG_W, S_CFG_P, S_CFG_T,
    S_A_W, S_A_ID, S_A_RD, S_A_UPD,
    S_R_W1, S_R_W2, S_R_E1, S_R_E2, S_REPLY
  } state_e;

  state_e              state_q, state_d;
  pclb_pkg::status_e   status_q, status_d;
  logic                clr_reply_q, clr_reply_d;
  logic                cfg_pend_q, cfg_pend_d;
  logic                done_q;

  // a register write seen outside idle is kept and recomputed once idle
  assign busy_o = (state_q != S_IDLE) || cfg_wr_i || cfg_pend_q;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    clr_reply_d = clr_reply_q;
    cfg_pend_d  = cfg_pend_q | cfg_wr_i;
    cmd_o       = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          clr_reply_d = 1'b0;
          status_d    = pclb_pkg::ST_OK;
          state_d     = clr_reply_q ? S_REPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_wr_i || cfg_pend_q) begin
          cfg_pend_d = 1'b0;
          state_d    = S_CFG_S;
        end else if (start_i) begin
          cmd_o.accept = 1'b1;
          unique case (op_i)
            pclb_pkg::OP_CLEAR: begin
              cmd_o.clr_state = 1'b1;
              clr_reply_d     = 1'b1;
              state_d         = S_CLEAR;
            end
            pclb_pkg::OP_NOP: begin
              status_d = pclb_pkg::ST_OK;
              state_d  = S_REPLY;
            end
            pclb_pkg::OP_ADD: begin
              priority if (stat_i.too_large) begin
                status_d = pclb_pkg::ST_TOO_LARGE;
                state_d  = S_REPLY;
              end else if (stat_i.exhausted) begin
                status_d = pclb_pkg::ST_FULL;
                state_d  = S_REPLY;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_src   = pclb_pkg::DIV_POS;
                state_d         = S_A_W;
              end
            end
            pclb_pkg::OP_READ: begin
              priority if (stat_i.too_large) begin
                status_d = pclb_pkg::ST_TOO_LARGE;
                state_d  = S_REPLY;
              end else if (stat_i.idx_out) begin
                status_d = pclb_pkg::ST_OUTSIDE;
                state_d  = S_REPLY;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_src   = pclb_pkg::DIV_IDX;
                state_d         = S_R_W1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CFG_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = pclb_pkg::DIV_CFG;
        state_d         = S_CFG_W;
      end
      S_CFG_W: begin
        if (stat_i.div_done) begin
          cmd_o.cfg_n = 1'b1;
          state_d     = S_CFG_P;
        end
      end
      S_CFG_P: begin
        cmd_o.cfg_p = 1'b1;
        state_d     = S_CFG_T;
      end
      S_CFG_T: begin
        cmd_o.cfg_t = 1'b1;
        state_d     = S_IDLE;
      end
      S_A_W: begin
        if (stat_i.div_done) begin
          cmd_o.add_chk = 1'b1;
          state_d       = S_A_ID;
        end
      end
      S_A_ID: begin
        if (!stat_i.in_range) begin
          status_d = pclb_pkg::ST_OUTSIDE;
          state_d  = S_REPLY;
        end else begin
          cmd_o.add_id = 1'b1;
          state_d      = S_A_RD;
        end
      end
      S_A_RD: begin
        state_d = S_A_UPD;
      end
      S_A_UPD: begin
        cmd_o.add_upd = 1'b1;
        status_d      = stat_i.full ? pclb_pkg::ST_FULL : pclb_pkg::ST_OK;
        state_d       = S_REPLY;
      end
      S_R_W1: begin
        if (stat_i.div_done) begin
          cmd_o.cap_cx    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = pclb_pkg::DIV_REM;
          state_d         = S_R_W2;
        end
      end
      S_R_W2: begin
        if (stat_i.div_done) begin
          cmd_o.rd_ent = 1'b1;
          if (stat_i.empty) begin
            status_d = pclb_pkg::ST_EMPTY;
            state_d  = S_REPLY;
          end else begin
            state_d = S_R_E1;
          end
        end
      end
      S_R_E1: begin
        state_d = S_R_E2;
      end
      S_R_E2: begin
        cmd_o.rd_fin = 1'b1;
        status_d     = pclb_pkg::ST_OK;
        state_d      = S_REPLY;
      end
      S_REPLY: begin
        cmd_o.reply = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      status_q    <= pclb_pkg::ST_OK;
      clr_reply_q <= 1'b0;
      cfg_pend_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      clr_reply_q <= clr_reply_d;
      cfg_pend_q  <= cfg_pend_d;
      done_q      <= (state_q == S_REPLY);
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/particle_cell_list_binner.sv
// top level of the particle cell list binner: config registers and glue
// depends on pclb_pkg, pclb_ctrl, pclb_dp (and pclb_div below it)
//
//  channel   handshake                         payload
//  --------  --------------------------------  ---------------------------
//  command   start && !busy                    in_i  (pclb_pkg::in_word_t)
//  result    done_o, one cycle, no backpress.  res_o (pclb_pkg::out_word_t)
//  config    psel & penable & pwrite, pready=1 paddr / pwdata / prdata
//
// add: three 33 step dividers run side by side on
// x, y and z, then range check, id, count read and update
// read: two passes of one divider (id / plane, then
// rest / nz) and one entry memory read
// clear and the pass after reset sweep every entry of the count memory
// a config write keeps busy high while the axis counts are recomputed
// every accepted word gives exactly one result word; results cannot stall
module particle_cell_list_binner #(
  parameter int unsigned MAX_CELLS     = 4096,
  parameter int unsigned CELL_CAPACITY = 16,
  parameter int unsigned MAX_PARTICLES = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command side
  input  logic                            start,
  output logic                            busy,
  input  pclb_pkg::in_word_t              in_i,
  // result side
  output logic                            done_o,
  output pclb_pkg::out_word_t             res_o,
  // config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pclb_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [31:0] cell_len_q, box_x_q, box_y_q, box_z_q;
  logic        cfg_wr;
  pclb_pkg::cfg_reg_e reg_sel;
  pclb_pkg::cmd_t     cmd;
  pclb_pkg::stat_t    stat;
  logic               accept;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = pclb_pkg::cfg_reg_e'(paddr[3:2]);
  assign accept  = start & ~busy;

  // config registers: to be written only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_len_q <= pclb_pkg::RST_CELL_LEN;
      box_x_q    <= pclb_pkg::RST_BOX_LEN;
      box_y_q    <= pclb_pkg::RST_BOX_LEN;
      box_z_q    <= pclb_pkg::RST_BOX_LEN;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        pclb_pkg::REG_CELL_LEN: cell_len_q <= pwdata;
        pclb_pkg::REG_BOX_X:    box_x_q    <= pwdata;
        pclb_pkg::REG_BOX_Y:    box_y_q    <= pwdata;
        pclb_pkg::REG_BOX_Z:    box_z_q    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pclb_pkg::REG_CELL_LEN: prdata = cell_len_q;
      pclb_pkg::REG_BOX_X:    prdata = box_x_q;
      pclb_pkg::REG_BOX_Y:    prdata = box_y_q;
      pclb_pkg::REG_BOX_Z:    prdata = box_z_q;
      default:                prdata = '0;
    endcase
  end

  // sequencer
  pclb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .cfg_wr_i(cfg_wr),
    .op_i    (pclb_pkg::op_e'(in_i.operation)),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // dividers, memories and result register
  pclb_dp #(
    .MAX_CELLS    (MAX_CELLS),
    .CELL_CAPACITY(CELL_CAPACITY),
    .MAX_PARTICLES(MAX_PARTICLES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_i      (in_i),
    .cell_len_i(cell_len_q),
    .box_x_i   (box_x_q),
    .box_y_i   (box_y_q),
    .box_z_i   (box_z_q),
    .res_o     (res_o)
  );

endmodule

FILE: tb/testbench.sv
// self-checking testbench for particle_cell_list_binner: directed table, then random
// command words, checked against hand-typed results or an in-bench cell list predictor
// depends on rtl/pclb_pkg.sv and rtl/particle_cell_list_binner.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCELLS   = 4096;
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned NUMBERS  = 65536;
  localparam int          WD_LIMIT = 20000;

  // one directed row: command word plus an optional hand-typed result
  typedef struct {
    pclb_pkg::in_word_t  cmd;
    bit                  typed;
    pclb_pkg::out_word_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  pclb_pkg::in_word_t  in_i = '0;
  logic        done_o;
  pclb_pkg::out_word_t res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [pclb_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the block state and registers
  logic [31:0] bin_regs [4];
  logic [4:0]  bin_counts [NCELLS];
  logic [15:0] bin_entries [NCELLS*CAPACITY];
  int unsigned next_number;
  int unsigned top_count;
  int unsigned axis_n [3];
  int unsigned last_cell;

  pclb_pkg::out_word_t pending_res [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  row_t        rows [$];

  particle_cell_list_binner uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned cells_on_axis(logic [31:0] box, logic [31:0] cl);
    longint unsigned q;
    if (cl == 0) return 8191;
    q = (longint'(box) + longint'(cl) - 1) / longint'(cl);
    return (q > 8191) ? 8191 : int'(q);
  endfunction

  function automatic void refresh_axes();
    axis_n[0] = cells_on_axis(bin_regs[pclb_pkg::REG_BOX_X], bin_regs[pclb_pkg::REG_CELL_LEN]);
    axis_n[1] = cells_on_axis(bin_regs[pclb_pkg::REG_BOX_Y], bin_regs[pclb_pkg::REG_CELL_LEN]);
    axis_n[2] = cells_on_axis(bin_regs[pclb_pkg::REG_BOX_Z], bin_regs[pclb_pkg::REG_CELL_LEN]);
  endfunction

  function automatic longint unsigned grid_cells();
    return longint'(axis_n[0]) * longint'(axis_n[1]) * longint'(axis_n[2]);
  endfunction

  function automatic void empty_grid();
    foreach (bin_counts[i]) bin_counts[i] = '0;
    next_number = 0;
    top_count = 0;
  endfunction

  // works out the result word of one command and advances the state
  function automatic pclb_pkg::out_word_t bin_particle(pclb_pkg::in_word_t w);
    pclb_pkg::out_word_t r;
    longint unsigned     tot;
    int unsigned         nx, ny, nz, px, py, pz, id, c, plane, rest;
    pclb_pkg::op_e       op;
    r = '0;
    tot = grid_cells();
    nx = axis_n[0]; ny = axis_n[1]; nz = axis_n[2];
    op = pclb_pkg::op_e'(w.operation);
    if (op == pclb_pkg::OP_CLEAR) begin
      empty_grid();
      r.status = pclb_pkg::ST_OK;
    end else if (op != pclb_pkg::OP_NOP && tot > NCELLS) begin
      r.status = pclb_pkg::ST_TOO_LARGE;
    end else if (op == pclb_pkg::OP_ADD) begin
      if (next_number >= NUMBERS) begin
        r.status = pclb_pkg::ST_FULL;
      end else begin
        px = w.pos_x / bin_regs[pclb_pkg::REG_CELL_LEN];
        py = w.pos_y / bin_regs[pclb_pkg::REG_CELL_LEN];
        pz = w.pos_z / bin_regs[pclb_pkg::REG_CELL_LEN];
        r.particle_number = next_number[15:0];
        next_number++;
        if (px >= nx || py >= ny || pz >= nz) begin
          r.status = pclb_pkg::ST_OUTSIDE;
        end else begin
          id = pz + nz * py + nz * ny * px;
          last_cell = id;
          r.cell_id = id[11:0];
          r.cell_x = px[11:0];
          r.cell_y = py[11:0];
          r.cell_z = pz[11:0];
          c = bin_counts[id];
          if (c >= CAPACITY) begin
            r.status = pclb_pkg::ST_FULL;
          end else begin
            bin_entries[id * CAPACITY + c] = r.particle_number;
            c++;
            bin_counts[id] = c[4:0];
            if (c > top_count) top_count = c;
            r.status = pclb_pkg::ST_OK;
          end
          r.cell_count = c[4:0];
        end
      end
    end else if (op == pclb_pkg::OP_READ) begin
      r.cell_id = w.cell_index;
      if (longint'(w.cell_index) >= tot) begin
        r.status = pclb_pkg::ST_OUTSIDE;
      end else begin
        plane = ny * nz;
        rest = w.cell_index % plane;
        r.cell_x = 12'(w.cell_index / plane);
        r.cell_y = 12'(rest / nz);
        r.cell_z = 12'(rest % nz);
        c = bin_counts[w.cell_index];
        r.cell_count = c[4:0];
        if (w.slot >= c) r.status = pclb_pkg::ST_EMPTY;
        else r.particle_number = bin_entries[w.cell_index * CAPACITY + (c - 1 - w.slot)];
      end
    end
    r.max_count = top_count[4:0];
    r.total_cells = (tot > 8191) ? 13'd8191 : 13'(tot);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    pclb_pkg::out_word_t e;
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %p", $time, res_o);
        errors++;
      end else begin
        e = pending_res.pop_front();
        check_field("status", res_o.status, e.status);
        check_field("cell_id", res_o.cell_id, e.cell_id);
        check_field("cell_x", res_o.cell_x, e.cell_x);
        check_field("cell_y", res_o.cell_y, e.cell_y);
        check_field("cell_z", res_o.cell_z, e.cell_z);
        check_field("cell_count", res_o.cell_count, e.cell_count);
        check_field("max_count", res_o.max_count, e.max_count);
        check_field("particle_number", res_o.particle_number, e.particle_number);
        check_field("total_cells", res_o.total_cells, e.total_cells);
      end
    end
  end

  // watchdog: cycles in which neither a command nor a result word moves
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("%0t watchdog expired, %0d words outstanding", $time, pending_res.size());
      $display("[particle_cell_list_binner] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // start stays high across back-to-back words; prediction at acceptance
  task automatic send_word(pclb_pkg::in_word_t w, bit typed, pclb_pkg::out_word_t typed_res,
                           int gap);
    pclb_pkg::out_word_t p;
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    in_i = w;
    do @(posedge clk_i); while (busy);
    p = bin_particle(w);
    pending_res.push_back(typed ? typed_res : p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
  endtask

  // register write with setup and access cycles, then read back
  task automatic write_reg(pclb_pkg::cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = pclb_pkg::CFG_AW'({idx, 2'b00}); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    check_field("register readback", prdata, val);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
    bin_regs[idx] = val;
    refresh_axes();
    do @(posedge clk_i); while (busy);
  endtask

  task automatic set_grid(logic [31:0] cl, logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    drain();
    write_reg(pclb_pkg::REG_CELL_LEN, cl);
    write_reg(pclb_pkg::REG_BOX_X, bx);
    write_reg(pclb_pkg::REG_BOX_Y, by);
    write_reg(pclb_pkg::REG_BOX_Z, bz);
  endtask

  // random word: mostly adds inside the box and reads of live cells
  function automatic pclb_pkg::in_word_t pick_word();
    pclb_pkg::in_word_t w;
    int                 r;
    longint unsigned    tot;
    int unsigned        idx;
    w.operation = 2'($urandom);
    w.pos_x = $urandom; w.pos_y = $urandom; w.pos_z = $urandom;
    w.cell_index = 12'($urandom);
    w.slot = 4'($urandom);
    r = $urandom_range(0, 99);
    tot = grid_cells();
    if (r < 55) begin
      w.operation = pclb_pkg::OP_ADD;
      if (bin_regs[pclb_pkg::REG_BOX_X] != 0) w.pos_x = $urandom % bin_regs[pclb_pkg::REG_BOX_X];
      if (bin_regs[pclb_pkg::REG_BOX_Y] != 0) w.pos_y = $urandom % bin_regs[pclb_pkg::REG_BOX_Y];
      if (bin_regs[pclb_pkg::REG_BOX_Z] != 0) w.pos_z = $urandom % bin_regs[pclb_pkg::REG_BOX_Z];
    end else if (r < 85) begin
      w.operation = pclb_pkg::OP_READ;
      if (tot >= 1 && tot <= NCELLS) begin
        idx = (r < 70 && last_cell < tot) ? last_cell : $urandom_range(0, int'(tot) - 1);
        w.cell_index = idx[11:0];
        if (r < 80 && bin_counts[idx] != 0)
          w.slot = 4'($urandom_range(0, bin_counts[idx] - 1));
      end
    end else if (r < 88) begin
      w.operation = pclb_pkg::OP_CLEAR;
    end else if (r < 91) begin
      w.operation = pclb_pkg::OP_NOP;
    end
    return w;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      send_word(pick_word(), 1'b0, '0, pick_gap());
    end
  endtask

  function automatic pclb_pkg::in_word_t cmd(pclb_pkg::op_e op, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [11:0] idx, logic [3:0] s);
    pclb_pkg::in_word_t w;
    w.operation = op; w.pos_x = x; w.pos_y = y; w.pos_z = z;
    w.cell_index = idx; w.slot = s;
    return w;
  endfunction

  function automatic pclb_pkg::out_word_t res(pclb_pkg::status_e st, logic [11:0] id,
                                              logic [11:0] x, logic [11:0] y, logic [11:0] z,
                                              logic [4:0] c, logic [4:0] m, logic [15:0] p,
                                              logic [12:0] t);
    pclb_pkg::out_word_t r;
    r.status = st; r.cell_id = id; r.cell_x = x; r.cell_y = y; r.cell_z = z;
    r.cell_count = c; r.max_count = m; r.particle_number = p; r.total_cells = t;
    return r;
  endfunction

  function automatic void add_row(pclb_pkg::in_word_t w, bit typed = 1'b0,
                                  pclb_pkg::out_word_t r = '0);
    rows.push_back('{cmd: w, typed: typed, res: r});
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    pclb_pkg::in_word_t w;
    bin_regs[pclb_pkg::REG_CELL_LEN] = pclb_pkg::RST_CELL_LEN;
    bin_regs[pclb_pkg::REG_BOX_X] = pclb_pkg::RST_BOX_LEN;
    bin_regs[pclb_pkg::REG_BOX_Y] = pclb_pkg::RST_BOX_LEN;
    bin_regs[pclb_pkg::REG_BOX_Z] = pclb_pkg::RST_BOX_LEN;
    refresh_axes();
    empty_grid();
    last_cell = 0;

    // directed rows on the reset grid of 16 x 16 x 16 cells
    add_row(cmd(pclb_pkg::OP_READ, 0, 0, 0, 12'd0, 4'd0), 1,
            res(pclb_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 13'd4096));
    add_row(cmd(pclb_pkg::OP_READ, 0, 0, 0, 12'd4095, 4'd15), 1,
            res(pclb_pkg::ST_EMPTY, 12'd4095, 15, 15, 15, 0, 0, 0, 13'd4096));
    add_row(cmd(pclb_pkg::OP_ADD, 0, 0, 0, 0, 0), 1,
            res(pclb_pkg::ST_OK, 0, 0, 0, 0, 1, 1, 0, 13'd4096));
    add_row(cmd(pclb_pkg::OP_ADD, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 0, 0), 1,
            res(pclb_pkg::ST_OK, 12'd4095, 15, 15, 15, 1, 1, 1, 13'd4096));
    // just past the box edge, then all ones
    add_row(cmd(pclb_pkg::OP_ADD, 32'h0010_0000, 0, 0, 0, 0), 1,
            res(pclb_pkg::ST_OUTSIDE, 0, 0, 0, 0, 0, 1, 2, 13'd4096));
    add_row(cmd(pclb_pkg::OP_ADD, '1, '1, '1, '1, '1), 1,
            res(pclb_pkg::ST_OUTSIDE, 0, 0, 0, 0, 0, 1, 3, 13'd4096));
    add_row(cmd(pclb_pkg::OP_ADD, 32'h0001_8000, 32'h0002_8000, 32'h0003_8000, 0, 0));
    add_row(cmd(pclb_pkg::OP_ADD, 32'h0000_FFFF, 32'h0000_0001, 32'h0000_8000,
                12'hA5A, 4'h5));
    add_row(cmd(pclb_pkg::OP_READ, '1, '1, '1, 12'd0, 4'd0));
    add_row(cmd(pclb_pkg::OP_READ, 0, 0, 0, 12'd0, 4'd1));
    add_row(cmd(pclb_pkg::OP_READ, 0, 0, 0, 12'd0, 4'd2));
    add_row(cmd(pclb_pkg::OP_READ, 0, 0, 0, 12'd291, 4'd0));
    add_row(cmd(pclb_pkg::OP_NOP, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                12'h5A5, 4'hA));
    add_row(cmd(pclb_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 1,
            res(pclb_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 13'd4096));
    add_row(cmd(pclb_pkg::OP_READ, 0, 0, 0, 12'd0, 4'd0));
    add_row(cmd(pclb_pkg::OP_ADD, 32'h000A_5A5A, 32'h0005_A5A5, 32'h000F_0F0F, 0, 0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_word(rows[i].cmd, rows[i].typed, rows[i].res, pick_gap());
    run_random(100);

    // small grid of 2 x 3 x 4 cells, so cells fill up
    set_grid(32'h0004_0000, 32'h0008_0000, 32'h000C_0000, 32'h0010_0000);
    run_random(150);

    // single cell: largest cell length, smallest box, full cell reached fast
    set_grid('1, 32'd1, 32'd1, 32'd1);
    run_random(50);

    // zero cell length saturates every axis, grid too large
    set_grid(32'd0, pclb_pkg::RST_BOX_LEN, pclb_pkg::RST_BOX_LEN, pclb_pkg::RST_BOX_LEN);
    run_random(15);

    // zero box along x, no cells at all
    set_grid(pclb_pkg::RST_CELL_LEN, 32'd0, pclb_pkg::RST_BOX_LEN, pclb_pkg::RST_BOX_LEN);
    run_random(15);

    // tiny cell and huge box saturate the axis counts
    set_grid(32'd1, '1, '1, '1);
    run_random(15);

    // back to the full 4096 cell grid
    set_grid(pclb_pkg::RST_CELL_LEN, pclb_pkg::RST_BOX_LEN, pclb_pkg::RST_BOX_LEN,
             pclb_pkg::RST_BOX_LEN);
    run_random(200);

    // fill the one cell of a single cell grid past capacity, back to back
    set_grid('1, 32'd1, 32'd1, 32'd1);
    calm = 1'b1;
    send_word(cmd(pclb_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 0, '0, 0);
    for (int i = 0; i < 20; i++) begin
      w = cmd(pclb_pkg::OP_ADD, $urandom, $urandom, $urandom, 0, 0);
      if (i % 2 == 0) w.pos_x = 0;
      send_word(w, 0, '0, 0);
    end
    send_word(cmd(pclb_pkg::OP_READ, 0, 0, 0, 12'd0, 4'd0), 0, '0, 0);
    send_word(cmd(pclb_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 0, '0, 0);
    calm = 1'b0;
    run_random(30);

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[particle_cell_list_binner] OK");
    end else begin
      $display("[particle_cell_list_binner] ERROR");
    end
    $finish;
  end

endmodule
